### sv/common_prime_matcher_defines.svh
// Assertion macros for the common prime matcher checker.
`ifndef COMMON_PRIME_MATCHER_DEFINES_SVH
`define COMMON_PRIME_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CPM_AST_IMM(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CPM_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpm: next-cycle check failed");

`endif

### sv/cpm_pkg.sv
package cpm_pkg;

    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;
    localparam int HIT_W   = 9;
    localparam int TOTAL_W = 17;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int LIST_DEPTH_DEF = 256;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;

    // trial divisor and its square; divisors stay below 2^16 for 31-bit values
    localparam int DIV_W  = 16;
    localparam int SQ_W   = 32;
    // remainder unit: bits retired per cycle and division steps per divisor
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = VAL_W / DIV_BITS;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic busy;
        logic is_prime;
    } t_prime_sts;

endpackage

### sv/cpm_if.sv
interface cpm_in_if;
    logic                               valid;
    logic                               ready;
    logic        [cpm_pkg::CMD_W-1:0]   command;
    logic signed [cpm_pkg::VAL_W-1:0]   value;
    logic                               final_probe;

    modport source (output valid, command, value, final_probe, input ready);
    modport sink   (input valid, command, value, final_probe, output ready);
endinterface

interface cpm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cpm_pkg::VAL_W-1:0]   probe_value;
    logic                               value_is_prime;
    logic        [cpm_pkg::HIT_W-1:0]   hit_count;
    logic        [cpm_pkg::TOTAL_W-1:0] running_total;
    logic                               run_done;

    modport source (output valid, probe_value, value_is_prime, hit_count, running_total,
                    run_done, input ready);
    modport sink   (input valid, probe_value, value_is_prime, hit_count, running_total,
                    run_done, output ready);
endinterface

### sv/cpm_prime.sv
module cpm_prime (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cpm_pkg::VAL_W-1:0]     i_value,
    output cpm_pkg::t_prime_sts           o_sts
);

    typedef enum logic [2:0] {
        P_IDLE  = 3'b001,
        P_CHECK = 3'b010,
        P_DIV   = 3'b100
    } t_pstate;

    t_pstate                         r_state;
    logic                            r_is_prime;
    logic [cpm_pkg::VAL_W-2:0]       r_n;
    logic [cpm_pkg::DIV_W-1:0]       r_d;
    logic [cpm_pkg::SQ_W-1:0]        r_dsq;
    logic [cpm_pkg::DIV_W-1:0]       r_rem;
    logic [cpm_pkg::VAL_W-1:0]       r_sh;
    logic [cpm_pkg::DCNT_W-1:0]      r_cnt;

    logic [cpm_pkg::DIV_W-1:0]       n_rem;
    logic [cpm_pkg::DIV_W:0]         ext;

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb begin
        n_rem = r_rem;
        ext   = '0;
        for (int i = 0; i < cpm_pkg::DIV_BITS; i++) begin
            ext = {n_rem, r_sh[cpm_pkg::VAL_W-1-i]};
            if (ext >= {1'b0, r_d}) begin
                ext = ext - {1'b0, r_d};
            end
            n_rem = ext[cpm_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= P_IDLE;
            r_is_prime <= 1'b0;
        end else if (i_start) begin
            priority if (i_value[cpm_pkg::VAL_W-1] || i_value[cpm_pkg::VAL_W-2:0] < 2) begin
                r_is_prime <= 1'b0;
                r_state    <= P_IDLE;
            end else if (i_value[cpm_pkg::VAL_W-2:0] < 4) begin
                r_is_prime <= 1'b1;
                r_state    <= P_IDLE;
            end else if (!i_value[0]) begin
                r_is_prime <= 1'b0;
                r_state    <= P_IDLE;
            end else begin
                r_state    <= P_CHECK;
            end
        end else begin
            unique case (r_state)
                P_IDLE: begin
                end
                P_CHECK: begin
                    if (r_dsq > {1'b0, r_n}) begin
                        r_is_prime <= 1'b1;
                        r_state    <= P_IDLE;
                    end else begin
                        r_state    <= P_DIV;
                    end
                end
                P_DIV: begin
                    if (r_cnt == cpm_pkg::DCNT_W'(cpm_pkg::DIV_CYCLES - 1)) begin
                        if (n_rem == '0) begin
                            r_is_prime <= 1'b0;
                            r_state    <= P_IDLE;
                        end else begin
                            r_state    <= P_CHECK;
                        end
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_value[cpm_pkg::VAL_W-2:0];
            r_d   <= cpm_pkg::DIV_W'(3);
            r_dsq <= cpm_pkg::SQ_W'(9);
        end else if (r_state == P_CHECK) begin
            r_rem <= '0;
            r_sh  <= {1'b0, r_n};
            r_cnt <= '0;
        end else if (r_state == P_DIV) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[cpm_pkg::VAL_W-1-cpm_pkg::DIV_BITS:0], {cpm_pkg::DIV_BITS{1'b0}}};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == cpm_pkg::DCNT_W'(cpm_pkg::DIV_CYCLES - 1)) begin
                // (d+2)^2 = d^2 + 4d + 4
                r_d   <= r_d + cpm_pkg::DIV_W'(2);
                r_dsq <= r_dsq + cpm_pkg::SQ_W'({r_d, 2'b00}) + cpm_pkg::SQ_W'(4);
            end
        end
    end

    assign o_sts.busy     = (r_state != P_IDLE);
    assign o_sts.is_prime = r_is_prime;

endmodule

### sv/common_prime_matcher.sv
// Channel  Dir  Role    Word
// i_in     in   sink    command, value, final_probe
// o_out    out  source  probe_value, value_is_prime, hit_count, running_total, run_done
//
// Clear and store words keep the block idle; store writes the list memory at
// the fill count. A probe scans the stored list while it runs trial division by
// odd divisors up to sqrt(value) on the single 4-bit-per-cycle remainder unit;
// negative, small and even values skip the division. The next word is taken
// once both are done.
// Reset clears the fill count, the pair total and the control state; the list itself
// is not cleared and only entries below the fill count are ever compared.
// The result register frees the input side: a new word is taken while a result waits;
// a finished probe holds in its run state until the result register is free.
module common_prime_matcher #(
    parameter int LIST_DEPTH = cpm_pkg::LIST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpm_in_if.sink     i_in,
    cpm_out_if.source  o_out
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                             r_state;
    logic [cpm_pkg::VAL_W-1:0]          r_mem [LIST_DEPTH];
    logic [cpm_pkg::VAL_W-1:0]          r_rd_data;
    logic                               r_rd_vld;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_scan_idx;
    logic                               r_scan_on;
    logic [CW-1:0]                      r_hits;
    logic [cpm_pkg::TOTAL_W-1:0]        r_total;
    logic [cpm_pkg::VAL_W-1:0]          r_val;
    logic                               r_final;

    logic                               r_out_vld;
    logic [cpm_pkg::VAL_W-1:0]          r_out_val;
    logic                               r_out_prime;
    logic [cpm_pkg::HIT_W-1:0]          r_out_hits;
    logic [cpm_pkg::TOTAL_W-1:0]        r_out_total;
    logic                               r_out_done;

    logic                               acc_in;
    logic                               do_store;
    logic                               start_probe;
    logic                               fin;
    logic [CW-1:0]                      hits_eff;
    logic [cpm_pkg::TOTAL_W:0]          sum;
    logic [cpm_pkg::TOTAL_W-1:0]        n_total;
    cpm_pkg::t_prime_sts                prime_sts;

    assign i_in.ready  = (r_state == S_IDLE);
    assign acc_in      = i_in.valid && i_in.ready;
    assign do_store    = acc_in && (i_in.command == cpm_pkg::CMD_STORE)
                         && (r_count != CW'(LIST_DEPTH));
    assign start_probe = acc_in && (i_in.command == cpm_pkg::CMD_PROBE);

    cpm_prime u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_probe),
        .i_value (i_in.value),
        .o_sts   (prime_sts)
    );

    assign fin = (r_state == S_RUN) && !prime_sts.busy && !r_scan_on && !r_rd_vld
                 && (!r_out_vld || o_out.ready);

    assign hits_eff = prime_sts.is_prime ? r_hits : '0;
    assign sum      = {1'b0, r_total} + (cpm_pkg::TOTAL_W + 1)'(hits_eff);
    assign n_total  = (sum > {1'b0, cpm_pkg::TOTAL_MAX}) ? cpm_pkg::TOTAL_MAX
                                                         : sum[cpm_pkg::TOTAL_W-1:0];

    // list memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_count[AW-1:0]] <= i_in.value;
        end
        r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_scan_on <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (fin) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld <= (r_state == S_RUN) && r_scan_on;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        unique case (i_in.command)
                            cpm_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                            end
                            cpm_pkg::CMD_STORE: begin
                                if (do_store) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            cpm_pkg::CMD_PROBE: begin
                                r_scan_on <= (r_count != '0);
                                r_state   <= S_RUN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_scan_on && (r_scan_idx + 1'b1 == r_count)) begin
                        r_scan_on <= 1'b0;
                    end
                    if (fin) begin
                        r_total   <= r_final ? '0 : n_total;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // probe datapath and result word
    always_ff @(posedge i_clk) begin
        if (start_probe) begin
            r_val      <= i_in.value;
            r_final    <= i_in.final_probe;
            r_hits     <= '0;
            r_scan_idx <= '0;
        end else if (r_state == S_RUN) begin
            if (r_scan_on) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_rd_vld && (r_rd_data == r_val)) begin
                r_hits <= r_hits + 1'b1;
            end
        end
        if (fin) begin
            r_out_val   <= r_val;
            r_out_prime <= prime_sts.is_prime;
            r_out_hits  <= (cpm_pkg::HIT_W)'(hits_eff);
            r_out_total <= n_total;
            r_out_done  <= r_final;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.probe_value    = r_out_val;
    assign o_out.value_is_prime = r_out_prime;
    assign o_out.hit_count      = r_out_hits;
    assign o_out.running_total  = r_out_total;
    assign o_out.run_done       = r_out_done;

endmodule

### sv/cpm_check.sv
`include "common_prime_matcher_defines.svh"

module cpm_check (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [cpm_pkg::VAL_W-1:0]   i_probe_value,
    input logic                               i_value_is_prime,
    input logic        [cpm_pkg::HIT_W-1:0]   i_hit_count,
    input logic        [cpm_pkg::TOTAL_W-1:0] i_running_total
);

    `CPM_AST_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_probe_value) && $stable(i_running_total))
    `CPM_AST_IMM(a_hit_prime, i_clk, i_rst_n, i_out_valid && (i_hit_count != '0), i_value_is_prime)
    `CPM_AST_IMM(a_small_not_prime, i_clk, i_rst_n, i_out_valid && (i_probe_value < 32'sd2), !i_value_is_prime)
    `CPM_AST_IMM(a_total_covers, i_clk, i_rst_n, i_out_valid, i_running_total >= {8'd0, i_hit_count})

endmodule

bind common_prime_matcher cpm_check u_cpm_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_probe_value    (o_out.probe_value),
    .i_value_is_prime (o_out.value_is_prime),
    .i_hit_count      (o_out.hit_count),
    .i_running_total  (o_out.running_total)
);

### dv/tb_common_prime_matcher.sv
module tb_common_prime_matcher;

    localparam int LIST_DEPTH     = cpm_pkg::LIST_DEPTH_DEF;
    localparam int ITEM_TARGET    = 1170;
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int HOLD_AFTER     = 560;
    localparam int TAIL_CYCLES    = 64;

    localparam logic [cpm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [cpm_pkg::CMD_W-1:0]        cmd;
        logic signed [cpm_pkg::VAL_W-1:0] value;
        logic                             final_probe;
    } t_cmd_word;

    typedef struct {
        logic signed [cpm_pkg::VAL_W-1:0] probe_value;
        logic                             is_prime;
        logic [cpm_pkg::HIT_W-1:0]        hits;
        logic [cpm_pkg::TOTAL_W-1:0]      total;
        logic                             done;
    } t_probe_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpm_in_if  in_ch ();
    cpm_out_if out_ch ();

    common_prime_matcher #(
        .LIST_DEPTH (LIST_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    t_cmd_word     cmd_words[$];
    t_probe_result due_results[$];
    t_cmd_word     cur_word;

    // shadow of the block's list and pair total
    logic signed [cpm_pkg::VAL_W-1:0] list_mem [LIST_DEPTH];
    int list_len = 0;
    int pair_sum = 0;

    int prime_pool [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97, 251, 257, 7919, 65521};

    bit quiet     = 1'b0;
    bit sink_hold = 1'b0;

    int words_queued  = 0;
    int words_taken   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int probes_taken  = 0;
    int primes_taken  = 0;
    int hits_seen     = 0;
    int full_drops    = 0;
    int saturations   = 0;
    int stall_cycles  = 0;

    function automatic bit is_prime_by_division(logic signed [cpm_pkg::VAL_W-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v <= 1) return 1'b0;
        n = longint'(v);
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void track_word(t_cmd_word w);
        t_probe_result r;
        int hits;
        int sum;
        hits = 0;
        case (w.cmd)
            cpm_pkg::CMD_CLEAR: begin
                list_len = 0;
                pair_sum = 0;
            end
            cpm_pkg::CMD_STORE: begin
                if (list_len < LIST_DEPTH) begin
                    list_mem[list_len] = w.value;
                    list_len++;
                end else begin
                    full_drops++;
                end
            end
            cpm_pkg::CMD_PROBE: begin
                r.is_prime = is_prime_by_division(w.value);
                if (r.is_prime) begin
                    for (int k = 0; k < list_len; k++) begin
                        if (list_mem[k] == w.value) hits++;
                    end
                    primes_taken++;
                end
                sum = pair_sum + hits;
                if (sum > int'(cpm_pkg::TOTAL_MAX)) begin
                    sum = int'(cpm_pkg::TOTAL_MAX);
                    saturations++;
                end
                pair_sum      = sum;
                r.probe_value = w.value;
                r.hits        = hits[cpm_pkg::HIT_W-1:0];
                r.total       = sum[cpm_pkg::TOTAL_W-1:0];
                r.done        = w.final_probe;
                due_results.push_back(r);
                if (w.final_probe) pair_sum = 0;
                probes_taken++;
                hits_seen += hits;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_word(input logic [cpm_pkg::CMD_W-1:0] c,
                              input logic signed [cpm_pkg::VAL_W-1:0] v,
                              input logic f);
        t_cmd_word w;
        w.cmd         = c;
        w.value       = v;
        w.final_probe = f;
        cmd_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (cmd_words.size() != 0 || in_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // full range; positive values kept even so trial division stays short
    function automatic logic signed [cpm_pkg::VAL_W-1:0] wide_value();
        logic signed [cpm_pkg::VAL_W-1:0] v;
        v    = $urandom;
        v[0] = v[cpm_pkg::VAL_W-1];
        return v;
    endfunction

    function automatic logic signed [cpm_pkg::VAL_W-1:0] small_value();
        return int'($urandom_range(0, 5020)) - 20;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_word(cur_word);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
                    cur_word          = cmd_words.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.command     <= cur_word.cmd;
                    in_ch.value       <= cur_word.value;
                    in_ch.final_probe <= cur_word.final_probe;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_probe_result r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for value %0d",
                                              out_ch.probe_value));
                end else begin
                    r = due_results.pop_front();
                    if (out_ch.probe_value !== r.probe_value)
                        report_mismatch($sformatf("probe_value got %0d want %0d",
                                                  out_ch.probe_value, r.probe_value));
                    if (out_ch.value_is_prime !== r.is_prime)
                        report_mismatch($sformatf("value_is_prime got %b want %b for %0d",
                                                  out_ch.value_is_prime, r.is_prime,
                                                  r.probe_value));
                    if (out_ch.hit_count !== r.hits)
                        report_mismatch($sformatf("hit_count got %0d want %0d for %0d",
                                                  out_ch.hit_count, r.hits, r.probe_value));
                    if (out_ch.running_total !== r.total)
                        report_mismatch($sformatf("running_total got %0d want %0d for %0d",
                                                  out_ch.running_total, r.total,
                                                  r.probe_value));
                    if (out_ch.run_done !== r.done)
                        report_mismatch($sformatf("run_done got %b want %b for %0d",
                                                  out_ch.run_done, r.done, r.probe_value));
                end
            end
            out_ch.ready <= !sink_hold && (quiet || $urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (results_seen >= HOLD_AFTER);
        @(negedge i_clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin : stim
        int j;
        int n_items;
        int roll;
        int pick;
        int run_no;
        int sat_prime;
        logic signed [cpm_pkg::VAL_W-1:0] v;
        logic signed [cpm_pkg::VAL_W-1:0] run_vals[$];

        in_ch.valid       = 1'b0;
        in_ch.command     = cpm_pkg::CMD_CLEAR;
        in_ch.value       = '0;
        in_ch.final_probe = 1'b0;
        out_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_word(cpm_pkg::CMD_PROBE, 0, 1'b0);
        queue_word(cpm_pkg::CMD_STORE, 7, 1'b1);
        queue_word(cpm_pkg::CMD_STORE, 7, 1'b0);
        queue_word(cpm_pkg::CMD_STORE, -7, 1'b0);
        queue_word(cpm_pkg::CMD_STORE, 32'sh7FFFFFFF, 1'b0);
        queue_word(cpm_pkg::CMD_STORE, 32'sh80000000, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 7, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, -7, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 1, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 2, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 32'sh80000000, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 9, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, 32'sh7FFFFFFE, 1'b0);
        queue_word(CMD_UNUSED, -1, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, 32'sh7FFFFFFF, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, 7, 1'b0);
        queue_word(cpm_pkg::CMD_CLEAR, -1, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, 7, 1'b0);
        queue_word(cpm_pkg::CMD_STORE, 3, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, 3, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, 3, 1'b0);
        queue_word(cpm_pkg::CMD_CLEAR, 0, 1'b0);
        wait_idle();

        // fill the list with one prime, overflow it, then drive the total into saturation
        quiet     = 1'b1;
        sat_prime = prime_pool[$urandom_range(0, 10)];
        queue_word(cpm_pkg::CMD_CLEAR, $urandom, rand_bit());
        for (j = 0; j < LIST_DEPTH; j++)
            queue_word(cpm_pkg::CMD_STORE, sat_prime, rand_bit());
        for (j = 0; j < 3; j++) queue_word(cpm_pkg::CMD_STORE, wide_value(), rand_bit());
        for (j = 0; j < 514; j++) queue_word(cpm_pkg::CMD_PROBE, sat_prime, 1'b0);
        queue_word(cpm_pkg::CMD_PROBE, sat_prime, 1'b1);
        queue_word(cpm_pkg::CMD_PROBE, sat_prime, 1'b0);
        wait_idle();
        quiet = 1'b0;

        run_no = 0;
        while (words_queued < ITEM_TARGET) begin
            n_items = $urandom_range(2, 30);
            run_vals.delete();
            if ($urandom_range(0, 99) < 70)
                queue_word(cpm_pkg::CMD_CLEAR, $urandom, rand_bit());
            for (j = 0; j < n_items; j++) begin
                roll = (j == n_items - 1) ? 50 : $urandom_range(0, 99);
                pick = $urandom_range(0, 99);
                if (roll < 45) begin
                    if (pick < 60) v = prime_pool[$urandom_range(0, 15)];
                    else if (pick < 80) v = small_value();
                    else v = wide_value();
                    queue_word(cpm_pkg::CMD_STORE, v, rand_bit());
                    run_vals.push_back(v);
                end else if (roll < 92) begin
                    if (run_vals.size() != 0 && pick < 55)
                        v = run_vals[$urandom_range(0, run_vals.size() - 1)];
                    else if (pick < 75) v = prime_pool[$urandom_range(0, 15)];
                    else if (pick < 95) v = small_value();
                    else v = wide_value();
                    queue_word(cpm_pkg::CMD_PROBE, v,
                               (j == n_items - 1) && ($urandom_range(0, 99) < 85));
                end else if (roll < 96) begin
                    queue_word(CMD_UNUSED, $urandom, rand_bit());
                end else begin
                    queue_word(cpm_pkg::CMD_CLEAR, $urandom, rand_bit());
                    run_vals.delete();
                end
            end
            run_no++;
            if (run_no % 6 == 0) wait_idle();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d probes (%0d prime), %0d matching pairs",
                 words_taken, probes_taken, primes_taken, hits_seen);
        $display("stores dropped on a full list: %0d, saturated totals: %0d, mismatches: %0d",
                 full_drops, saturations, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/cpm_pkg.sv
sv/cpm_if.sv
sv/cpm_prime.sv
sv/common_prime_matcher.sv
sv/cpm_check.sv
dv/tb_common_prime_matcher.sv
